FILE: sv/cel_pkg.sv
`timescale 1ns / 1ps

package cel_pkg;

  localparam int unsigned ProbW        = 16;
  localparam int unsigned ProbFracBits = 15;
  localparam int unsigned GradW        = 32;
  localparam int unsigned ValW         = 48;
  localparam int unsigned FracW        = 16;
  localparam int unsigned SqSteps      = 16;
  localparam int unsigned DivBitsPerCycle = 3;
  localparam int unsigned DivSteps     = ValW / DivBitsPerCycle;
  localparam int unsigned CntW         = 4;
  localparam logic [31:0] Ln2Q32       = 32'd2977044472;
  localparam logic [ProbW-1:0] FloorReset = 16'd1;

  localparam logic CmdForward  = 1'b0;
  localparam logic CmdBackward = 1'b1;
  localparam logic KindLoss    = 1'b0;
  localparam logic KindGrad    = 1'b1;

  typedef struct packed {
    logic                    command;
    logic [ProbW-1:0]        prediction;
    logic [ProbW-1:0]        target;
    logic signed [GradW-1:0] upstream_grad;
    logic                    last;
  } in_t;

  typedef struct packed {
    logic                   kind;
    logic signed [ValW-1:0] value;
    logic                   saturated;
  } out_t;

  typedef struct packed {
    logic load;
    logic norm;
    logic sq;
    logic ln;
    logic nl;
    logic term;
    logic acc;
    logic gmul;
    logic dinit;
    logic dstep;
    logic gout;
  } cel_cmd_t;

  typedef struct packed {
    logic command;
    logic last;
    logic out_free;
  } cel_stat_t;

endpackage

FILE: sv/cel_ctrl.sv
`timescale 1ns / 1ps

module cel_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cel_pkg::cel_stat_t stat_i,
  output cel_pkg::cel_cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_NORM  = 4'd1;
  localparam logic [3:0] S_SQ    = 4'd2;
  localparam logic [3:0] S_LN    = 4'd3;
  localparam logic [3:0] S_NL    = 4'd4;
  localparam logic [3:0] S_TERM  = 4'd5;
  localparam logic [3:0] S_ACC   = 4'd6;
  localparam logic [3:0] S_GMUL  = 4'd7;
  localparam logic [3:0] S_DINIT = 4'd8;
  localparam logic [3:0] S_DIV   = 4'd9;
  localparam logic [3:0] S_GOUT  = 4'd10;

  logic [3:0] state_q, state_d;
  logic [cel_pkg::CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_NORM;
        end
      end
      S_NORM: begin
        if (stat_i.command == cel_pkg::CmdBackward) begin
          state_d = S_GMUL;
        end else begin
          cmd_o.norm = 1'b1;
          cnt_d      = '0;
          state_d    = S_SQ;
        end
      end
      S_SQ: begin
        cmd_o.sq = 1'b1;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == cel_pkg::CntW'(cel_pkg::SqSteps - 1)) begin
          state_d = S_LN;
        end
      end
      S_LN: begin
        cmd_o.ln = 1'b1;
        state_d  = S_NL;
      end
      S_NL: begin
        cmd_o.nl = 1'b1;
        state_d  = S_TERM;
      end
      S_TERM: begin
        cmd_o.term = 1'b1;
        state_d    = S_ACC;
      end
      S_ACC: begin
        if (!stat_i.last || stat_i.out_free) begin
          cmd_o.acc = 1'b1;
          state_d   = S_IDLE;
        end
      end
      S_GMUL: begin
        cmd_o.gmul = 1'b1;
        state_d    = S_DINIT;
      end
      S_DINIT: begin
        cmd_o.dinit = 1'b1;
        cnt_d       = '0;
        state_d     = S_DIV;
      end
      S_DIV: begin
        cmd_o.dstep = 1'b1;
        cnt_d       = cnt_q + 1'b1;
        if (cnt_q == cel_pkg::CntW'(cel_pkg::DivSteps - 1)) begin
          state_d = S_GOUT;
        end
      end
      S_GOUT: begin
        if (stat_i.out_free) begin
          cmd_o.gout = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

FILE: sv/cel_datapath.sv
`timescale 1ns / 1ps

module cel_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cel_pkg::in_t                  in_data_i,
  input  logic                          cfg_we_i,
  input  logic [cel_pkg::ProbW-1:0]     cfg_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output cel_pkg::out_t                 out_data_o,
  input  cel_pkg::cel_cmd_t             cmd_i,
  output cel_pkg::cel_stat_t            stat_o
);

  localparam int unsigned PW = cel_pkg::ProbW;
  localparam int unsigned VW = cel_pkg::ValW;
  localparam int unsigned FW = cel_pkg::FracW;

  logic [PW-1:0] floor_q;
  logic signed [VW-1:0] loss_sum_q;
  logic sum_sat_q;
  logic out_valid_q;
  cel_pkg::out_t out_q;

  logic cmd_q, last_q, neg_q, sign_q;
  logic [PW-1:0] tgt_q, p_q;
  logic [31:0] umag_q;
  logic [3:0] e_q;
  logic [31:0] m_q;
  logic [FW-1:0] frac_q;
  logic [63:0] prod_q;
  logic [20:0] nl_q;
  logic [VW-1:0] dvd_q;
  logic [PW-1:0] rem_q;

  logic [PW-1:0] floor_eff, p_in;
  logic [3:0] lead;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [31:0] sq_val;
  logic signed [22:0] n2_s;
  logic [22:0] n2_mag;
  logic [63:0] nl_sum, tm_sum;
  logic [23:0] tmag;
  logic signed [VW:0] term_s, sum_s;
  logic acc_sat;
  logic signed [VW-1:0] sum_c;
  logic [VW-1:0] dvd_n;
  logic [PW-1:0] rem_n;
  logic [PW:0] r17;
  logic out_free;

  assign floor_eff = (floor_q == '0) ? PW'(1) : floor_q;
  assign p_in = (in_data_i.prediction < floor_eff) ? floor_eff : in_data_i.prediction;

  always_comb begin
    lead = '0;
    for (int i = 0; i < PW; i++) begin
      if (p_q[i]) lead = 4'(i);
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd_i.sq) begin
      mul_a = m_q;
      mul_b = m_q;
    end else if (cmd_i.ln) begin
      mul_a = 32'(n2_mag);
      mul_b = cel_pkg::Ln2Q32;
    end else if (cmd_i.term) begin
      mul_a = 32'(tgt_q);
      mul_b = 32'(nl_q);
    end else if (cmd_i.gmul) begin
      mul_a = umag_q;
      mul_b = 32'(tgt_q);
    end
  end
  assign mul_p = mul_a * mul_b;
  assign sq_val = mul_p[61:30];

  always_comb begin
    n2_s = ((23'(cel_pkg::ProbFracBits) - 23'(e_q)) <<< 16) - 23'(frac_q);
    n2_mag = n2_s[22] ? 23'(-n2_s) : 23'(n2_s);
  end

  assign nl_sum = prod_q + 64'h0000_0000_8000_0000;
  assign tm_sum = prod_q + 64'(1 << (cel_pkg::ProbFracBits - 1));
  assign tmag = tm_sum[cel_pkg::ProbFracBits +: 24];

  always_comb begin
    term_s = sign_q ? -$signed({25'b0, tmag}) : $signed({25'b0, tmag});
    sum_s = $signed({loss_sum_q[VW-1], loss_sum_q}) + term_s;
    acc_sat = sum_s[VW] != sum_s[VW-1];
    if (acc_sat) begin
      sum_c = sum_s[VW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
    end else begin
      sum_c = sum_s[VW-1:0];
    end
  end

  always_comb begin
    dvd_n = dvd_q;
    rem_n = rem_q;
    r17 = '0;
    for (int i = 0; i < cel_pkg::DivBitsPerCycle; i++) begin
      r17 = {rem_n, dvd_n[VW-1]};
      dvd_n = {dvd_n[VW-2:0], 1'b0};
      if (r17 >= {1'b0, p_q}) begin
        r17 = r17 - {1'b0, p_q};
        dvd_n[0] = 1'b1;
      end
      rem_n = r17[PW-1:0];
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q     <= cel_pkg::FloorReset;
      loss_sum_q  <= '0;
      sum_sat_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) floor_q <= cfg_data_i;
      if (cmd_i.gout || (cmd_i.acc && last_q)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.acc) begin
        if (last_q) begin
          loss_sum_q  <= '0;
          sum_sat_q   <= 1'b0;
        end else begin
          loss_sum_q <= sum_c;
          sum_sat_q  <= sum_sat_q | acc_sat;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q  <= in_data_i.command;
      last_q <= in_data_i.last;
      tgt_q  <= in_data_i.target;
      neg_q  <= in_data_i.upstream_grad[cel_pkg::GradW-1];
      umag_q <= in_data_i.upstream_grad[cel_pkg::GradW-1] ?
                32'(-in_data_i.upstream_grad) : 32'(in_data_i.upstream_grad);
      p_q    <= p_in;
    end
    if (cmd_i.norm) begin
      e_q    <= lead;
      m_q    <= 32'(p_q) << (5'd30 - {1'b0, lead});
      frac_q <= '0;
    end
    if (cmd_i.sq) begin
      m_q    <= sq_val[31] ? {1'b0, sq_val[31:1]} : sq_val;
      frac_q <= {frac_q[FW-2:0], sq_val[31]};
    end
    if (cmd_i.ln) begin
      prod_q <= mul_p;
      sign_q <= n2_s[22];
    end
    if (cmd_i.nl) nl_q <= nl_sum[52:32];
    if (cmd_i.term || cmd_i.gmul) prod_q <= mul_p;
    if (cmd_i.dinit) begin
      dvd_q <= prod_q[VW-1:0] + VW'(p_q[PW-1:1]);
      rem_q <= '0;
    end
    if (cmd_i.dstep) begin
      dvd_q <= dvd_n;
      rem_q <= rem_n;
    end
    if (cmd_i.acc && last_q) begin
      out_q.kind      <= cel_pkg::KindLoss;
      out_q.value     <= sum_c;
      out_q.saturated <= sum_sat_q | acc_sat;
    end
    if (cmd_i.gout) begin
      out_q.kind      <= cel_pkg::KindGrad;
      out_q.value     <= neg_q ? $signed(dvd_q) : -$signed(dvd_q);
      out_q.saturated <= 1'b0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;
  assign stat_o.command  = cmd_q;
  assign stat_o.last     = last_q;
  assign stat_o.out_free = out_free;

endmodule

FILE: sv/cross_entropy_loss_unit.sv
`timescale 1ns / 1ps

// channel   signals                              transaction
// in        in_valid_i, in_ready_o, in_data_i    one prediction/target element
// out       out_valid_o, out_ready_i, out_data_o sample loss or element gradient
// cfg       cfg_we_i, cfg_data_i                 clamp floor write
//
// forward item: 16 squaring steps on the shared 32x32 multiplier plus log
//   scaling and accumulate
// backward item: a 48-bit divide at 3 quotient bits per cycle
// one item in flight; a finished result waits in the output register while
//   the next item is taken, and a second result stalls until it drains
// async active-low reset clears the sum, sticky flag, floor (to 1) and control

module cross_entropy_loss_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  cel_pkg::in_t              in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output cel_pkg::out_t             out_data_o,
  input  logic                      cfg_we_i,
  input  logic [cel_pkg::ProbW-1:0] cfg_data_i
);

  cel_pkg::cel_cmd_t  cmd;
  cel_pkg::cel_stat_t stat;

  cel_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  cel_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam longint VmaxQ = 64'sd140737488355327;
  localparam longint VminQ = -64'sd140737488355328;
  localparam int LimitCycles = 400000;
  localparam int DrainCycles = 40;

  typedef struct {
    cel_pkg::in_t  item;
    bit            fixed;
    cel_pkg::out_t want;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  cel_pkg::in_t in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  cel_pkg::out_t out_data_o;
  logic cfg_we_i;
  logic [cel_pkg::ProbW-1:0] cfg_data_i;

  cross_entropy_loss_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  // shadow copy of the block state
  logic [cel_pkg::ProbW-1:0] floor_q;
  longint loss_acc_q;
  bit acc_clip_q;

  cel_pkg::out_t pending_q[$];
  int errs;
  int cyc;
  stim_row_t rows[$];

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > LimitCycles) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic longint round_div_pow2(longint v, int s);
    bit neg;
    longint unsigned mag;
    neg = v < 0;
    mag = neg ? longint'(0) - v : v;
    mag = (mag + (64'd1 << (s - 1))) >> s;
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint minus_ln_q16(int unsigned p);
    int e;
    longint unsigned m;
    int unsigned frac;
    longint n2;
    e = 15;
    frac = 0;
    while (e > 0 && p[e] == 1'b0) e--;
    m = longint'(p) << (30 - e);
    for (int i = 0; i < cel_pkg::SqSteps; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        frac = frac | 1;
        m = m >> 1;
      end
    end
    n2 = (longint'(cel_pkg::ProbFracBits) - e) * 65536 - longint'(frac);
    return round_div_pow2(n2 * longint'({32'd0, cel_pkg::Ln2Q32}), 32);
  endfunction

  // returns 1 when the item produces a result
  function automatic bit loss_grad_predict(cel_pkg::in_t x, output cel_pkg::out_t r);
    int unsigned fl;
    int unsigned p;
    longint s;
    longint unsigned umag;
    longint unsigned quo;
    longint v;
    fl = (floor_q == 0) ? 1 : floor_q;
    p = (x.prediction < fl) ? fl : x.prediction;
    r = '0;
    if (x.command == cel_pkg::CmdForward) begin
      s = loss_acc_q + round_div_pow2(longint'(x.target) * minus_ln_q16(p),
                                      cel_pkg::ProbFracBits);
      if (s > VmaxQ) begin
        s = VmaxQ;
        acc_clip_q = 1'b1;
      end
      if (s < VminQ) begin
        s = VminQ;
        acc_clip_q = 1'b1;
      end
      loss_acc_q = s;
      if (!x.last) return 1'b0;
      r.kind = cel_pkg::KindLoss;
      r.value = s[cel_pkg::ValW-1:0];
      r.saturated = acc_clip_q;
      loss_acc_q = 0;
      acc_clip_q = 1'b0;
      return 1'b1;
    end
    umag = x.upstream_grad[31] ? (64'h1_0000_0000 - {32'd0, x.upstream_grad})
                               : {32'd0, x.upstream_grad};
    quo = (umag * x.target + p / 2) / p;
    v = x.upstream_grad[31] ? longint'(quo) : -longint'(quo);
    r.kind = cel_pkg::KindGrad;
    r.saturated = 1'b0;
    if (v > VmaxQ) begin
      v = VmaxQ;
      r.saturated = 1'b1;
    end
    if (v < VminQ) begin
      v = VminQ;
      r.saturated = 1'b1;
    end
    r.value = v[cel_pkg::ValW-1:0];
    return 1'b1;
  endfunction

  function automatic stim_row_t mk_row(logic c, int p, int t, logic [31:0] g, logic l,
                                       bit fx, logic k, longint v);
    stim_row_t s;
    s.item.command = c;
    s.item.prediction = 16'(p);
    s.item.target = 16'(t);
    s.item.upstream_grad = g;
    s.item.last = l;
    s.fixed = fx;
    s.want.kind = k;
    s.want.value = v[cel_pkg::ValW-1:0];
    s.want.saturated = 1'b0;
    return s;
  endfunction

  // drive one transaction, return at the edge where it is taken
  task automatic send_item(cel_pkg::in_t x, bit fx, cel_pkg::out_t want);
    int gap;
    cel_pkg::out_t r;
    bit has;
    gap = $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= x;
    forever begin
      @(negedge clk_i);
      if (in_ready_o) break;
    end
    @(posedge clk_i);
    has = loss_grad_predict(x, r);
    if (fx) begin
      if (!has || r !== want) begin
        $display("%0t table row mismatch: expected %h predicted %h", $time, want, r);
        errs++;
      end
      pending_q.push_back(want);
    end else if (has) begin
      pending_q.push_back(r);
    end
  endtask

  task automatic settle_and_write(logic [cel_pkg::ProbW-1:0] fl);
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= fl;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    floor_q = fl;
  endtask

  function automatic cel_pkg::in_t rand_item();
    cel_pkg::in_t x;
    int sel;
    x.command = $urandom_range(0, 2) == 0 ? cel_pkg::CmdBackward : cel_pkg::CmdForward;
    sel = $urandom_range(0, 9);
    if (sel == 0) x.prediction = 16'($urandom());
    else if (sel == 1) x.prediction = 16'($urandom_range(0, 64));
    else x.prediction = 16'($urandom_range(1, 32768));
    sel = $urandom_range(0, 9);
    if (sel == 0) x.target = 16'($urandom());
    else if (sel == 1) x.target = 16'd32768;
    else x.target = 16'($urandom_range(0, 32768));
    sel = $urandom_range(0, 9);
    if (sel == 0) x.upstream_grad = 32'h8000_0000;
    else if (sel == 1) x.upstream_grad = 32'h7fff_ffff;
    else x.upstream_grad = $urandom();
    x.last = $urandom_range(0, 3) == 0;
    return x;
  endfunction

  // output side
  initial begin
    cel_pkg::out_t got;
    cel_pkg::out_t exp_r;
    int stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      forever begin
        @(negedge clk_i);
        if (out_valid_o) break;
      end
      got = out_data_o;
      @(posedge clk_i);
      if (pending_q.size() == 0) begin
        $display("%0t unexpected transaction: expected none actual %h", $time, got);
        errs++;
      end else begin
        exp_r = pending_q.pop_front();
        if (got.kind !== exp_r.kind) begin
          $display("%0t kind: expected %h actual %h", $time, exp_r.kind, got.kind);
          errs++;
        end
        if (got.value !== exp_r.value) begin
          $display("%0t value: expected %h actual %h", $time, exp_r.value, got.value);
          errs++;
        end
        if (got.saturated !== exp_r.saturated) begin
          $display("%0t saturated: expected %h actual %h", $time, exp_r.saturated,
                   got.saturated);
          errs++;
        end
      end
    end
  end

  initial begin
    logic [cel_pkg::ProbW-1:0] floors[6];
    cel_pkg::out_t none;
    none = '0;
    floors = '{16'd0, 16'd32768, 16'd65535, 16'd300, 16'd1, 16'd0};
    floors[5] = 16'($urandom_range(2, 32768));
    errs = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_we_i = 1'b0;
    cfg_data_i = '0;
    floor_q = cel_pkg::FloorReset;
    loss_acc_q = 0;
    acc_clip_q = 1'b0;
    rows.push_back(mk_row(cel_pkg::CmdForward, 32768, 32768, 0, 1, 1, cel_pkg::KindLoss, 0));
    rows.push_back(mk_row(cel_pkg::CmdBackward, 32768, 0, 32'h7fff_ffff, 0, 1,
                          cel_pkg::KindGrad, 0));
    rows.push_back(mk_row(cel_pkg::CmdBackward, 32768, 32768, 32'h0001_0000, 0, 1,
                          cel_pkg::KindGrad, -65536));
    rows.push_back(mk_row(cel_pkg::CmdBackward, 32768, 32768, 32'h8000_0000, 0, 1,
                          cel_pkg::KindGrad, 64'sd2147483648));
    rows.push_back(mk_row(cel_pkg::CmdForward, 16384, 0, 0, 1, 1, cel_pkg::KindLoss, 0));
    rows.push_back(mk_row(cel_pkg::CmdForward, 0, 32768, 0, 0, 0, cel_pkg::KindLoss, 0));
    rows.push_back(mk_row(cel_pkg::CmdForward, 1, 65535, 32'hffff_ffff, 1, 0,
                          cel_pkg::KindLoss, 0));
    rows.push_back(mk_row(cel_pkg::CmdForward, 65535, 32768, 0, 1, 0, cel_pkg::KindLoss, 0));
    rows.push_back(mk_row(cel_pkg::CmdBackward, 0, 65535, 32'h7fff_ffff, 0, 0,
                          cel_pkg::KindGrad, 0));
    rows.push_back(mk_row(cel_pkg::CmdBackward, 1, 32768, 32'hffff_ffff, 0, 0,
                          cel_pkg::KindGrad, 0));
    rows.push_back(mk_row(cel_pkg::CmdBackward, 65535, 1, 32'h1234_5678, 1, 0,
                          cel_pkg::KindGrad, 0));
    rows.push_back(mk_row(cel_pkg::CmdBackward, 3, 65535, 32'h8000_0001, 0, 0,
                          cel_pkg::KindGrad, 0));
    rows.push_back(mk_row(cel_pkg::CmdForward, 12345, 20000, 0, 0, 0, cel_pkg::KindLoss, 0));
    rows.push_back(mk_row(cel_pkg::CmdForward, 40000, 32768, 32'h5555_aaaa, 0, 0,
                          cel_pkg::KindLoss, 0));
    rows.push_back(mk_row(cel_pkg::CmdForward, 2, 32768, 0, 1, 0, cel_pkg::KindLoss, 0));
    rows.push_back(mk_row(cel_pkg::CmdForward, 32767, 1, 0, 1, 0, cel_pkg::KindLoss, 0));
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) send_item(rows[i].item, rows[i].fixed, rows[i].want);
    foreach (floors[ph]) begin
      settle_and_write(floors[ph]);
      // two samples that sit at and just below the new floor
      send_item(mk_row(cel_pkg::CmdForward, floors[ph], 32768, 0, 1, 0, cel_pkg::KindLoss,
                       0).item, 0, none);
      send_item(mk_row(cel_pkg::CmdBackward, floors[ph] - 1, 32768, 32'hffff_0000, 0, 0,
                       cel_pkg::KindGrad, 0).item, 0, none);
      repeat (100) send_item(rand_item(), 0, none);
    end
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errs == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: cross_entropy_loss_unit.f
sv/cel_pkg.sv
sv/cel_ctrl.sv
sv/cel_datapath.sv
sv/cross_entropy_loss_unit.sv
tb/sv/tb.sv
